// File: src/lzw14_pkg.sv
// Package for the 14-bit LZW resource decompressor.
// Holds the code constants, table entry types and sequencer states.
// Used by lzw14_resource_decompressor; no dependencies.
package lzw14_pkg;

  localparam int unsigned HIST_AW = 16;
  localparam int unsigned TAB_AW = 14;
  localparam int unsigned LEN_W = 10;

  localparam logic [14:0] TABLE_SIZE = 15'd16384;
  localparam logic [LEN_W-1:0] MAX_STRING = 10'd512;

  localparam logic [13:0] CODE_END = 14'h3FFF;
  localparam logic [13:0] CODE_CLEAR = 14'h3FFE;
  localparam logic [13:0] FIRST_TOKEN = 14'h0100;

  typedef struct packed {
    logic              ovalid;
    logic [TAB_AW-1:0] origin;
    logic [HIST_AW-1:0] start;
  } tinfo_t;

  typedef struct packed {
    logic             lvalid;
    logic [LEN_W-1:0] len;
  } tlen_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DEC  = 7'b0000010,
    ST_LOOK = 7'b0000100,
    ST_ORIG = 7'b0001000,
    ST_CRD  = 7'b0010000,
    ST_CWR  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

endpackage

// File: src/lzw14_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic storage used for history and token tables; no dependencies.
module lzw14_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/lzw14_resource_decompressor.sv
// Top level of the 14-bit LZW resource decompressor: byte stream in,
// packed output bytes out. Depends on lzw14_pkg and lzw14_ram.
//
// The slave channel takes one packed code byte per item. The master channel
// returns items of up to eight unpacked bytes; tlast marks the last item
// caused by one input byte; tuser carries the done and error status. cfg_we_i
// writes the expected output size; the user, not the block, keeps it to idle.
//
// The block takes one input item at a time and is not ready again until the
// last result of that item has been loaded into the output register. Each
// output byte, literal or recalled, goes through a read state and then a write
// state, set by the single history port that is read and then written for
// every byte.
// The output register lets the sequencer go on while one result waits, and
// the sequencer stalls only when a second result is ready.
// Reset clears the code buffer, the token count, the output position and
// the status; no clearing pass is needed. A stall on the master channel
// holds the item and stops the copy until it is taken.
module lzw14_resource_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_bytes, byte_count, zero fill
  output logic        m_axis_tlast,   // run_last
  output logic [1:0]  m_axis_tuser    // stream_done, error_flag
);

  lzw14_pkg::state_e state_q, state_d;

  logic [16:0] out_size_q;
  logic [21:0] bit_buf_q;
  logic [4:0]  bit_cnt_q;
  logic [14:0] tcount_q;
  logic [16:0] outpos_q;
  logic        finished_q, error_q;
  logic [13:0] code_q;
  logic [13:0] idx_q;
  logic        lit_q;
  logic [9:0]  len_q, cnt_q;
  logic [15:0] start_q;
  logic [63:0] grp_q;
  logic [3:0]  gcnt_q;

  logic        m_valid_q;
  logic [67:0] m_data_q;
  logic        m_last_q;
  logic [1:0]  m_user_q;

  logic [21:0] nbuf;
  logic [4:0]  ncnt, rcnt;
  logic [21:0] shifted;
  logic        out_free;
  logic        accept;
  logic        m_load;

  logic                 hist_we, hist_re;
  logic [15:0]          hist_raddr;
  logic [7:0]           hist_rdata, emit_byte;
  logic                 tinfo_we, tab_re;
  lzw14_pkg::tinfo_t    tinfo_wdata, tinfo_rdata;
  logic                 tlen_we;
  logic [13:0]          tlen_waddr, tlen_raddr;
  lzw14_pkg::tlen_t     tlen_wdata, tlen_rdata;
  logic [13:0]          code_idx;
  logic [9:0]           orig_len;
  logic                 at_size;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == lzw14_pkg::ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;
  assign nbuf = {bit_buf_q[13:0], s_axis_tdata};
  assign ncnt = bit_cnt_q + 5'd8;
  assign rcnt = ncnt - 5'd14;
  assign shifted = nbuf >> rcnt;
  assign code_idx = code_q - lzw14_pkg::FIRST_TOKEN;
  assign orig_len = (tlen_rdata.lvalid ? tlen_rdata.len : 10'd1) + 10'd1;
  assign at_size = (outpos_q >= out_size_q);
  assign emit_byte = lit_q ? code_q[7:0] : hist_rdata;
  assign m_load = ((state_q == lzw14_pkg::ST_CWR) && hist_we && (gcnt_q == 4'd8))
                  || ((state_q == lzw14_pkg::ST_FIN) && out_free
                      && (gcnt_q != 4'd0 || finished_q || at_size));

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {4'd0, m_data_q};
  assign m_axis_tlast = m_last_q;
  assign m_axis_tuser = m_user_q;

  always_comb begin
    hist_we = (state_q == lzw14_pkg::ST_CWR) && !(gcnt_q == 4'd8 && !out_free);
    hist_re = (state_q == lzw14_pkg::ST_CRD);
    hist_raddr = start_q + {6'd0, cnt_q};
    tab_re = (state_q == lzw14_pkg::ST_DEC) || (state_q == lzw14_pkg::ST_LOOK);
    tinfo_we = (state_q == lzw14_pkg::ST_DEC) && (code_q != lzw14_pkg::CODE_END)
               && (code_q != lzw14_pkg::CODE_CLEAR) && !tcount_q[14]
               && ((code_q < lzw14_pkg::FIRST_TOKEN) || ({1'b0, code_idx} < tcount_q));
    tinfo_wdata.start = outpos_q[15:0];
    tinfo_wdata.origin = code_idx;
    tinfo_wdata.ovalid = (code_q >= lzw14_pkg::FIRST_TOKEN);
    tlen_raddr = (state_q == lzw14_pkg::ST_LOOK) ? tinfo_rdata.origin : code_idx;
    tlen_we = tinfo_we;
    tlen_waddr = tcount_q[13:0];
    tlen_wdata.lvalid = 1'b0;
    tlen_wdata.len = 10'd1;
    if (state_q == lzw14_pkg::ST_LOOK && !tlen_rdata.lvalid && !tinfo_rdata.ovalid) begin
      tlen_we = 1'b1;
      tlen_waddr = idx_q;
      tlen_wdata.lvalid = 1'b1;
      tlen_wdata.len = 10'd2;
    end else if (state_q == lzw14_pkg::ST_ORIG && orig_len <= lzw14_pkg::MAX_STRING) begin
      tlen_we = 1'b1;
      tlen_waddr = idx_q;
      tlen_wdata.lvalid = 1'b1;
      tlen_wdata.len = orig_len;
    end
  end

  lzw14_ram #(.DW(8), .AW(lzw14_pkg::HIST_AW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (outpos_q[15:0]),
    .wdata_i (emit_byte),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  lzw14_ram #(.DW($bits(lzw14_pkg::tinfo_t)), .AW(lzw14_pkg::TAB_AW)) u_tinfo (
    .clk_i   (clk_i),
    .we_i    (tinfo_we),
    .waddr_i (tcount_q[13:0]),
    .wdata_i (tinfo_wdata),
    .re_i    (state_q == lzw14_pkg::ST_DEC),
    .raddr_i (code_idx),
    .rdata_o (tinfo_rdata)
  );

  lzw14_ram #(.DW($bits(lzw14_pkg::tlen_t)), .AW(lzw14_pkg::TAB_AW)) u_tlen (
    .clk_i   (clk_i),
    .we_i    (tlen_we),
    .waddr_i (tlen_waddr),
    .wdata_i (tlen_wdata),
    .re_i    (tab_re),
    .raddr_i (tlen_raddr),
    .rdata_o (tlen_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lzw14_pkg::ST_IDLE: begin
        if (accept) begin
          if (finished_q || at_size || ncnt < 5'd14) begin
            state_d = lzw14_pkg::ST_FIN;
          end else begin
            state_d = lzw14_pkg::ST_DEC;
          end
        end
      end
      lzw14_pkg::ST_DEC: begin
        if (code_q == lzw14_pkg::CODE_END || code_q == lzw14_pkg::CODE_CLEAR) begin
          state_d = lzw14_pkg::ST_FIN;
        end else if (code_q < lzw14_pkg::FIRST_TOKEN) begin
          state_d = lzw14_pkg::ST_CRD;
        end else if ({1'b0, code_idx} >= tcount_q) begin
          state_d = lzw14_pkg::ST_FIN;
        end else begin
          state_d = lzw14_pkg::ST_LOOK;
        end
      end
      lzw14_pkg::ST_LOOK: begin
        state_d = (!tlen_rdata.lvalid && tinfo_rdata.ovalid) ? lzw14_pkg::ST_ORIG
                                                            : lzw14_pkg::ST_CRD;
      end
      lzw14_pkg::ST_ORIG: begin
        state_d = (orig_len > lzw14_pkg::MAX_STRING) ? lzw14_pkg::ST_FIN
                                                     : lzw14_pkg::ST_CRD;
      end
      lzw14_pkg::ST_CRD: begin
        if (cnt_q == len_q || at_size || outpos_q[16]) begin
          state_d = lzw14_pkg::ST_FIN;
        end else begin
          state_d = lzw14_pkg::ST_CWR;
        end
      end
      lzw14_pkg::ST_CWR: begin
        if (hist_we) begin
          state_d = lzw14_pkg::ST_CRD;
        end
      end
      lzw14_pkg::ST_FIN: begin
        if (out_free || (gcnt_q == 4'd0 && !(finished_q || at_size))) begin
          state_d = lzw14_pkg::ST_IDLE;
        end
      end
      default: state_d = lzw14_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzw14_pkg::ST_IDLE;
      out_size_q <= '0;
      bit_buf_q <= '0;
      bit_cnt_q <= '0;
      tcount_q <= '0;
      outpos_q <= '0;
      finished_q <= 1'b0;
      error_q <= 1'b0;
      gcnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        out_size_q <= cfg_wdata_i;
      end
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        lzw14_pkg::ST_IDLE: begin
          if (accept) begin
            if (!finished_q && at_size) begin
              finished_q <= 1'b1;
            end else if (!finished_q) begin
              bit_buf_q <= nbuf;
              bit_cnt_q <= (ncnt >= 5'd14) ? rcnt : ncnt;
            end
          end
        end
        lzw14_pkg::ST_DEC: begin
          if (code_q == lzw14_pkg::CODE_END) begin
            finished_q <= 1'b1;
          end else if (code_q == lzw14_pkg::CODE_CLEAR) begin
            tcount_q <= '0;
          end else if (code_q >= lzw14_pkg::FIRST_TOKEN && {1'b0, code_idx} >= tcount_q) begin
            finished_q <= 1'b1;
            error_q <= 1'b1;
          end else if (tinfo_we) begin
            tcount_q <= tcount_q + 15'd1;
          end
        end
        lzw14_pkg::ST_ORIG: begin
          if (orig_len > lzw14_pkg::MAX_STRING) begin
            finished_q <= 1'b1;
            error_q <= 1'b1;
          end
        end
        lzw14_pkg::ST_CRD: begin
          if (cnt_q != len_q) begin
            if (at_size) begin
              finished_q <= 1'b1;
            end else if (outpos_q[16]) begin
              finished_q <= 1'b1;
              error_q <= 1'b1;
            end
          end
        end
        lzw14_pkg::ST_CWR: begin
          if (hist_we) begin
            outpos_q <= outpos_q + 17'd1;
            if (gcnt_q == 4'd8) begin
              gcnt_q <= 4'd1;
            end else begin
              gcnt_q <= gcnt_q + 4'd1;
            end
          end
        end
        lzw14_pkg::ST_FIN: begin
          if (m_load) begin
            gcnt_q <= '0;
            finished_q <= finished_q | at_size;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lzw14_pkg::ST_IDLE: begin
        code_q <= shifted[13:0];
        lit_q <= 1'b1;
        len_q <= 10'd1;
        cnt_q <= '0;
      end
      lzw14_pkg::ST_DEC: begin
        idx_q <= code_idx;
        lit_q <= (code_q < lzw14_pkg::FIRST_TOKEN);
      end
      lzw14_pkg::ST_LOOK: begin
        start_q <= tinfo_rdata.start;
        len_q <= tlen_rdata.lvalid ? tlen_rdata.len : 10'd2;
      end
      lzw14_pkg::ST_ORIG: begin
        len_q <= orig_len;
      end
      lzw14_pkg::ST_CWR: begin
        if (hist_we) begin
          cnt_q <= cnt_q + 10'd1;
          if (gcnt_q == 4'd8) begin
            m_data_q <= {4'd8, grp_q};
            m_last_q <= 1'b0;
            m_user_q <= 2'b00;
            grp_q <= {56'd0, emit_byte};
          end else begin
            grp_q <= grp_q | ({56'd0, emit_byte} << {gcnt_q[2:0], 3'b000});
          end
        end
      end
      lzw14_pkg::ST_FIN: begin
        if (out_free) begin
          m_data_q <= {gcnt_q, grp_q};
          m_last_q <= 1'b1;
          m_user_q <= {error_q, finished_q | at_size};
          grp_q <= '0;
        end
      end
      default: ;
    endcase
    if (state_q == lzw14_pkg::ST_IDLE && accept) begin
      grp_q <= '0;
    end
  end

`ifndef SYNTHESIS
  a_gcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcnt_q <= 4'd8) else $error("Output group count out of range.");
  a_tcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= lzw14_pkg::TABLE_SIZE) else $error("Token count beyond table.");
  a_hist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> !outpos_q[16] && !at_size) else $error("History write out of range.");
`endif

endmodule

// File: sim/lzw14_checker.sv
`timescale 1ns / 100ps
// Checker for the 14-bit LZW resource decompressor: watches both stream channels,
// predicts the result items of every accepted byte and compares them in order.
// Depends on the port widths of lzw14_resource_decompressor only.
module lzw14_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          waiting_o,
  output int          checked_o,
  output int          out_pos_o
);

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned TAB_SIZE = 16384;
  localparam int unsigned LONGEST = 512;
  localparam logic [13:0] C_END = 14'h3FFF;
  localparam logic [13:0] C_CLEAR = 14'h3FFE;
  localparam logic [13:0] C_FIRST = 14'h0100;

  typedef struct {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic        error_flag;
  } word_t;

  logic [7:0]  hist [HIST_DEPTH];
  int unsigned tstart [TAB_SIZE];
  int unsigned tlen [TAB_SIZE];
  int unsigned torig [TAB_SIZE];
  bit          lvalid [TAB_SIZE];
  bit          ovalid [TAB_SIZE];
  logic [21:0] bitbuf;
  int unsigned nbits, ntok, pos, osize;
  bit          stopped, err_seen;
  logic [7:0]  unpacked [$];
  word_t       expected_words [$];

  assign waiting_o = expected_words.size();
  assign out_pos_o = pos;

  function automatic bit put_byte(logic [7:0] b);
    if (pos >= osize) begin
      stopped = 1;
      return 0;
    end
    if (pos >= HIST_DEPTH) begin
      stopped = 1;
      err_seen = 1;
      return 0;
    end
    hist[pos] = b;
    if (unpacked.size() < LONGEST) unpacked.push_back(b);
    pos++;
    return 1;
  endfunction

  function automatic void decode_code(logic [13:0] code);
    int unsigned idx, len, o, st;
    idx = 0;
    len = 1;
    if (code == C_END) begin
      stopped = 1;
      return;
    end
    if (code == C_CLEAR) begin
      foreach (lvalid[i]) begin
        lvalid[i] = 0;
        ovalid[i] = 0;
      end
      ntok = 0;
      return;
    end
    if (code >= C_FIRST) begin
      idx = code - C_FIRST;
      if (idx >= ntok) begin
        stopped = 1;
        err_seen = 1;
        return;
      end
    end
    if (ntok < TAB_SIZE) begin
      tstart[ntok] = pos;
      lvalid[ntok] = 0;
      ovalid[ntok] = 0;
      if (code >= C_FIRST) begin
        torig[ntok] = idx;
        ovalid[ntok] = 1;
      end
      ntok++;
    end
    if (code < C_FIRST) begin
      void'(put_byte(code[7:0]));
    end else begin
      if (lvalid[idx]) begin
        len = tlen[idx];
      end else begin
        if (ovalid[idx]) begin
          o = torig[idx];
          len = (lvalid[o] ? tlen[o] : 1) + 1;
        end else begin
          len = 2;
        end
        if (len > LONGEST) begin
          stopped = 1;
          err_seen = 1;
          return;
        end
        tlen[idx] = len;
        lvalid[idx] = 1;
      end
      st = tstart[idx];
      for (int i = 0; i < len; i++) begin
        if (!put_byte(hist[(st + i) % HIST_DEPTH])) break;
      end
    end
    if (pos >= osize) stopped = 1;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int unsigned nres;
    word_t w;
    unpacked.delete();
    if (!stopped && pos >= osize) stopped = 1;
    if (!stopped) begin
      bitbuf = {bitbuf[13:0], b};
      nbits += 8;
      if (nbits >= 14) begin
        nbits -= 14;
        decode_code(14'(bitbuf >> nbits));
      end
    end
    nres = (unpacked.size() + 7) / 8;
    if (nres == 0 && stopped) nres = 1;
    for (int k = 0; k < nres; k++) begin
      w.out_bytes = '0;
      w.byte_count = 0;
      for (int j = 0; j < 8 && k * 8 + j < unpacked.size(); j++) begin
        w.out_bytes[8*j +: 8] = unpacked[k * 8 + j];
        w.byte_count++;
      end
      w.run_last = (k + 1 == nres);
      w.stream_done = w.run_last && stopped;
      w.error_flag = w.run_last && err_seen;
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    word_t w;
    if (!rst_ni) begin
      foreach (lvalid[i]) begin
        lvalid[i] = 0;
        ovalid[i] = 0;
      end
      bitbuf = '0;
      nbits = 0;
      ntok = 0;
      pos = 0;
      osize = 0;
      stopped = 0;
      err_seen = 0;
      expected_words.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (expected_words.size() == 0) begin
          $error("unexpected result item: data %h user %b", m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          w = expected_words.pop_front();
          if (m_axis_tdata[63:0] !== w.out_bytes) begin
            $error("out_bytes: expected %h, got %h", w.out_bytes, m_axis_tdata[63:0]);
            fail_count_o++;
          end
          if (m_axis_tdata[67:64] !== w.byte_count) begin
            $error("byte_count: expected %0d, got %0d", w.byte_count, m_axis_tdata[67:64]);
            fail_count_o++;
          end
          if (m_axis_tlast !== w.run_last) begin
            $error("run_last: expected %b, got %b", w.run_last, m_axis_tlast);
            fail_count_o++;
          end
          if (m_axis_tuser[0] !== w.stream_done) begin
            $error("stream_done: expected %b, got %b", w.stream_done, m_axis_tuser[0]);
            fail_count_o++;
          end
          if (m_axis_tuser[1] !== w.error_flag) begin
            $error("error_flag: expected %b, got %b", w.error_flag, m_axis_tuser[1]);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) osize = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
    end
  end

endmodule

// File: sim/lzw14_resource_decompressor_test.sv
`timescale 1ns / 100ps
// Testbench top for lzw14_resource_decompressor: packs code streams into bytes,
// drives both channels with random idling and gives the verdict.
// Depends on the block and on lzw14_checker.
module lzw14_resource_decompressor_test;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [13:0] C_END = 14'h3FFF;
  localparam logic [13:0] C_CLEAR = 14'h3FFE;
  localparam logic [13:0] C_FIRST = 14'h0100;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  int fail_count, waiting, checked, out_pos;
  int send_idle, recv_idle, bytes_sent, ntok, quiet;
  int unsigned packer, packed_bits;
  bit hold_req;

  lzw14_resource_decompressor uut (.*);

  lzw14_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .fail_count_o(fail_count), .waiting_o(waiting), .checked_o(checked),
    .out_pos_o(out_pos)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic put_code(logic [13:0] c);
    packer = (packer << 14) | c;
    packed_bits += 14;
    while (packed_bits >= 8) begin
      packed_bits -= 8;
      send_byte(8'(packer >> packed_bits));
    end
    packer &= (1 << packed_bits) - 1;
    if (c == C_CLEAR) ntok = 0;
    else if (c < C_FIRST + ntok) ntok++;
  endtask

  task automatic random_code();
    int r;
    r = $urandom_range(99);
    if (r < 4) put_code(C_CLEAR);
    else if (r < 50 || ntok == 0) put_code(14'($urandom_range(255)));
    else if (r < 75) put_code(C_FIRST + 14'(ntok - 1 - $urandom_range(ntok > 3 ? 3 : ntok - 1)));
    else put_code(C_FIRST + 14'($urandom_range(ntok - 1)));
  endtask

  task automatic write_size(int unsigned v);
    s_axis_tvalid <= 0;
    while (waiting != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= 17'(v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin : stimulus
    int target;
    send_idle = 12;
    recv_idle = 52;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    write_size(65536);

    put_code(14'h00);
    put_code(14'hFF);
    put_code(C_FIRST);
    put_code(C_FIRST + 2);
    put_code(C_FIRST + 3);
    put_code(14'h5A);
    put_code(C_FIRST + 4);
    put_code(C_CLEAR);
    put_code(14'hA5);
    put_code(C_FIRST);
    put_code(C_FIRST + 1);
    put_code(C_FIRST + 1);
    while (bytes_sent < 110) random_code();

    write_size(out_pos + 30000 + $urandom_range(20000));
    send_idle = 52;
    recv_idle = 12;
    while (bytes_sent < 220) random_code();

    write_size(65536);
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1;
    while (bytes_sent < 320) random_code();

    case ($urandom_range(3))
      0: write_size(0);
      1: begin
        write_size(out_pos + $urandom_range(1, 6));
        for (int i = 0; i < 6 && ntok > 0; i++) put_code(C_FIRST + 14'(ntok - 1));
      end
      2: put_code(C_END);
      default: put_code(C_FIRST + 14'(ntok + $urandom_range(20)));
    endcase
    target = bytes_sent + 8;
    while (bytes_sent < target) send_byte(8'($urandom_range(255)));
    s_axis_tvalid <= 0;

    while (waiting != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Sent %0d code bytes, checked %0d result items.", bytes_sent, checked);
    $display("Unpacked %0d bytes before the stream stopped.", out_pos);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lzw14_pkg.sv
src/lzw14_ram.sv
src/lzw14_resource_decompressor.sv
sim/lzw14_checker.sv
sim/lzw14_resource_decompressor_test.sv
